[sv/spq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable priority queue package
// Shared constants, status and action codes, and the cell control type.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int PRIO_BITS_DEF   = 8;
    localparam int ID_BITS_DEF     = 16;

    localparam int ID_PORT_W   = 16;
    localparam int PRIO_PORT_W = 8;
    localparam int OCC_PORT_W  = 5;
    localparam int STATUS_W    = 2;

    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic enq;
        logic deq;
    } t_cell_ctl;

endpackage

[sv/spq_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable priority queue cell
// One slot of the sorted chain: holds, loads the new entry, takes its left
// neighbour on insert or its right neighbour on removal.
// ----------------------------------------------------------------------------
module spq_cell #(
    parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF,
    parameter int ID_BITS   = spq_pkg::ID_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  spq_pkg::t_cell_ctl   i_ctl,
    input  logic [ID_BITS-1:0]   i_new_id,
    input  logic [PRIO_BITS-1:0] i_new_prio,
    input  logic                 i_left_valid,
    input  logic                 i_left_keep,
    input  logic [ID_BITS-1:0]   i_left_id,
    input  logic [PRIO_BITS-1:0] i_left_prio,
    input  logic                 i_right_valid,
    input  logic [ID_BITS-1:0]   i_right_id,
    input  logic [PRIO_BITS-1:0] i_right_prio,
    output logic                 o_valid,
    output logic                 o_keep,
    output logic [ID_BITS-1:0]   o_id,
    output logic [PRIO_BITS-1:0] o_prio
);

    logic                 r_valid;
    logic [ID_BITS-1:0]   r_id;
    logic [PRIO_BITS-1:0] r_prio;
    logic                 n_valid;
    logic [ID_BITS-1:0]   n_id;
    logic [PRIO_BITS-1:0] n_prio;
    logic                 w_keep;

    assign w_keep = r_valid && (r_prio >= i_new_prio);

    always_comb begin
        n_valid = r_valid;
        n_id    = r_id;
        n_prio  = r_prio;
        if (i_ctl.enq && !w_keep) begin
            if (i_left_keep) begin
                n_valid = 1'b1;
                n_id    = i_new_id;
                n_prio  = i_new_prio;
            end else begin
                n_valid = i_left_valid;
                n_id    = i_left_id;
                n_prio  = i_left_prio;
            end
        end else if (i_ctl.deq) begin
            n_valid = i_right_valid;
            n_id    = i_right_id;
            n_prio  = i_right_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id   <= n_id;
        r_prio <= n_prio;
    end

    assign o_valid = r_valid;
    assign o_keep  = w_keep;
    assign o_id    = r_id;
    assign o_prio  = r_prio;

endmodule

[sv/stable_priority_queue_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable priority queue
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one command a beat:
//   i_action enqueue with i_entry_id and i_entry_priority, or dequeue.
//   Output channel (o_out_valid / i_out_stall) returns one result beat per
//   command: status, dequeued id and priority, occupancy after the command.
//   Entries sit in a chain of QUEUE_DEPTH cells kept sorted, highest
//   priority in cell 0, equal priorities in arrival order. All cells compare
//   the new priority at once and shift by one in the same cycle.
//   The result beat is registered and appears the cycle after the command is accepted.
//   Throughput: one command per cycle while the receiver does not stall, set by the single-step cell shift.
//   An enqueue into a full queue is dropped with status full; a dequeue on
//   an empty queue returns status empty with zero id and priority.
//   Reset (i_rst_n low, synchronous) empties the queue and the result
//   register. While the receiver stalls a waiting result, o_in_stall is
//   high and the result beat holds.
// ----------------------------------------------------------------------------
module stable_priority_queue_top #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF,
    parameter int PRIO_BITS   = spq_pkg::PRIO_BITS_DEF,
    parameter int ID_BITS     = spq_pkg::ID_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_action,
    input  logic [spq_pkg::ID_PORT_W-1:0]    i_entry_id,
    input  logic [spq_pkg::PRIO_PORT_W-1:0]  i_entry_priority,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [spq_pkg::STATUS_W-1:0]     o_status,
    output logic [spq_pkg::ID_PORT_W-1:0]    o_out_id,
    output logic [spq_pkg::PRIO_PORT_W-1:0]  o_out_priority,
    output logic [spq_pkg::OCC_PORT_W-1:0]   o_occupancy
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [31:0]          w_id_ext;
    logic [31:0]          w_prio_ext;
    logic [ID_BITS-1:0]   w_new_id;
    logic [PRIO_BITS-1:0] w_new_prio;
    logic                 w_in_acc;
    logic                 w_full;
    logic                 w_empty;
    spq_pkg::t_cell_ctl   w_ctl;

    logic [QUEUE_DEPTH-1:0] w_valid;
    logic [QUEUE_DEPTH-1:0] w_keep;
    logic [ID_BITS-1:0]     w_id   [QUEUE_DEPTH];
    logic [PRIO_BITS-1:0]   w_prio [QUEUE_DEPTH];

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    logic                            r_out_valid;
    logic [spq_pkg::STATUS_W-1:0]    r_status;
    logic [spq_pkg::ID_PORT_W-1:0]   r_out_id;
    logic [spq_pkg::PRIO_PORT_W-1:0] r_out_prio;
    logic [spq_pkg::OCC_PORT_W-1:0]  r_occ;
    logic [spq_pkg::STATUS_W-1:0]    n_status;
    logic [spq_pkg::ID_PORT_W-1:0]   n_out_id;
    logic [spq_pkg::PRIO_PORT_W-1:0] n_out_prio;
    logic [31:0]                     w_head_id;
    logic [31:0]                     w_head_prio;
    logic [31:0]                     w_occ_ext;

    assign w_id_ext   = 32'(i_entry_id);
    assign w_prio_ext = 32'(i_entry_priority);
    assign w_new_id   = w_id_ext[ID_BITS-1:0];
    assign w_new_prio = w_prio_ext[PRIO_BITS-1:0];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_full     = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_empty    = (r_count == '0);

    assign w_ctl.enq = w_in_acc && (i_action == spq_pkg::ACT_ENQ) && !w_full;
    assign w_ctl.deq = w_in_acc && (i_action == spq_pkg::ACT_DEQ) && !w_empty;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic                 w_lv;
        logic                 w_lk;
        logic [ID_BITS-1:0]   w_lid;
        logic [PRIO_BITS-1:0] w_lprio;
        logic                 w_rv;
        logic [ID_BITS-1:0]   w_rid;
        logic [PRIO_BITS-1:0] w_rprio;

        if (g == 0) begin : g_first
            assign w_lv    = 1'b0;
            assign w_lk    = 1'b1;
            assign w_lid   = '0;
            assign w_lprio = '0;
        end else begin : g_link_left
            assign w_lv    = w_valid[g-1];
            assign w_lk    = w_keep[g-1];
            assign w_lid   = w_id[g-1];
            assign w_lprio = w_prio[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign w_rv    = 1'b0;
            assign w_rid   = '0;
            assign w_rprio = '0;
        end else begin : g_link_right
            assign w_rv    = w_valid[g+1];
            assign w_rid   = w_id[g+1];
            assign w_rprio = w_prio[g+1];
        end

        spq_cell #(
            .PRIO_BITS (PRIO_BITS),
            .ID_BITS   (ID_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_new_id      (w_new_id),
            .i_new_prio    (w_new_prio),
            .i_left_valid  (w_lv),
            .i_left_keep   (w_lk),
            .i_left_id     (w_lid),
            .i_left_prio   (w_lprio),
            .i_right_valid (w_rv),
            .i_right_id    (w_rid),
            .i_right_prio  (w_rprio),
            .o_valid       (w_valid[g]),
            .o_keep        (w_keep[g]),
            .o_id          (w_id[g]),
            .o_prio        (w_prio[g])
        );
    end

    assign w_head_id   = 32'(w_id[0]);
    assign w_head_prio = 32'(w_prio[0]);

    always_comb begin
        n_count    = r_count;
        n_status   = spq_pkg::ST_OK;
        n_out_id   = '0;
        n_out_prio = '0;
        if (i_action == spq_pkg::ACT_ENQ) begin
            if (w_full) begin
                n_status = spq_pkg::ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (w_empty) begin
                n_status = spq_pkg::ST_EMPTY;
            end else begin
                n_count    = r_count - CNT_W'(1);
                n_out_id   = w_head_id[spq_pkg::ID_PORT_W-1:0];
                n_out_prio = w_head_prio[spq_pkg::PRIO_PORT_W-1:0];
            end
        end
    end

    assign w_occ_ext = 32'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_status   <= n_status;
            r_out_id   <= n_out_id;
            r_out_prio <= n_out_prio;
            r_occ      <= w_occ_ext[spq_pkg::OCC_PORT_W-1:0];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_out_id       = r_out_id;
    assign o_out_priority = r_out_prio;
    assign o_occupancy    = r_occ;

`ifndef SYNTHESIS
    logic w_order_ok;

    always_comb begin
        w_order_ok = 1'b1;
        for (int k = 1; k < QUEUE_DEPTH; k++) begin
            if (w_valid[k] && (w_prio[k] > w_prio[k-1])) begin
                w_order_ok = 1'b0;
            end
        end
    end

    a_count_matches_cells : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_count) == $countones(w_valid)))
        else $error("entry count differs from occupied cells");

    a_cells_packed : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (((w_valid + QUEUE_DEPTH'(1)) & w_valid) == '0))
        else $error("occupied cells are not packed from the head");

    a_cells_sorted : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_order_ok)
        else $error("cell chain out of priority order");

    a_deq_shrinks : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.deq |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("dequeue did not remove one entry");

    a_no_enq_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> !w_ctl.enq)
        else $error("insert issued into a full chain");
`endif

endmodule
